/* hw/rtl/bfsp_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bfsp_pkg
// Shared types and constants of the shortest-path engine.
// ----------------------------------------------------------------------------
package bfsp_pkg;

  localparam int unsigned MAX_NODES  = 64;
  localparam int unsigned NODE_BITS  = 6;
  localparam int unsigned DIST_BITS  = 22;
  localparam int unsigned NCFG_BITS  = 7;
  localparam int unsigned CFG_W      = 7;
  localparam int unsigned CFG_IDX_W  = 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_NODE_COUNT  = 1'b0,
    REG_SOURCE_NODE = 1'b1
  } bfsp_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_FETCH,
    ST_DREAD,
    ST_RELAX,
    ST_EMIT
  } bfsp_state_e;

  typedef struct packed {
    logic                 relax;
    logic                 under;
    logic [DIST_BITS-1:0] sum;
  } bfsp_relax_t;

endpackage

`default_nettype wire

/* hw/rtl/bellman_ford_shortest_paths.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bellman_ford_shortest_paths
// Single-source shortest paths over a stored edge list with a shared
// relaxation unit stepped by a small sequencer.
// ----------------------------------------------------------------------------
//  channel   signals                                          direction
//  command   start, busy, operation_i, edge_from_i, edge_to_i,  in
//            edge_weight_i (busy is an output)
//  result    result_valid_o, node_index_o, distance_o,          out
//            reachable_o, negative_cycle_o, last_o
//  config    cfg_we_i, cfg_idx_i, cfg_wdata_i                   in
//
//  an edge store is taken while idle; busy stays low
//  a run clears n distance entries, then makes n passes that step each stored
//  edge in turn through fetch, read and relax in the shared unit, then emits
//  one result per node or one negative-cycle result (n = node count in use)
//  results come as one strobe per cycle and cannot be stalled
//  reset clears the edge count and the sequencer; memories are not cleared
// ----------------------------------------------------------------------------
module bellman_ford_shortest_paths
  import bfsp_pkg::*;
#(
  parameter int unsigned MAX_EDGES   = 4096,
  parameter int unsigned WEIGHT_BITS = 16
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic                          cfg_we_i,
  input  wire logic        [CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic        [CFG_W-1:0]       cfg_wdata_i,
  input  wire logic                          operation_i,
  input  wire logic        [NODE_BITS-1:0]   edge_from_i,
  input  wire logic        [NODE_BITS-1:0]   edge_to_i,
  input  wire logic signed [WEIGHT_BITS-1:0] edge_weight_i,
  output logic                               result_valid_o,
  output logic             [NODE_BITS-1:0]   node_index_o,
  output logic signed      [DIST_BITS-1:0]   distance_o,
  output logic                               reachable_o,
  output logic                               negative_cycle_o,
  output logic                               last_o
);

  localparam int unsigned CNT_W  = $clog2(MAX_NODES + 1);
  localparam int unsigned IW     = $clog2(MAX_NODES);
  localparam int unsigned XW     = (CNT_W > NCFG_BITS) ? CNT_W : NCFG_BITS;
  localparam int unsigned EC_W   = $clog2(MAX_EDGES + 1);
  localparam int unsigned EA_W   = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int unsigned EDGE_W = 2 * NODE_BITS + WEIGHT_BITS;
  localparam int unsigned DREC_W = DIST_BITS + 1;

  bfsp_state_e state_q, state_d;

  logic [NCFG_BITS-1:0] node_count_q, node_count_d;
  logic [NODE_BITS-1:0] source_q, source_d;
  logic [NODE_BITS-1:0] src_run_q, src_run_d;
  logic [CNT_W-1:0]     n_q, n_d;
  logic [EC_W-1:0]      count_q, count_d;
  logic [EC_W-1:0]      ptr_q, ptr_d;
  logic [CNT_W-1:0]     pass_q, pass_d;
  logic [CNT_W-1:0]     idx_q, idx_d;
  logic                 under_q, under_d;
  logic                 out_vld_q, out_vld_d;
  logic                 out_neg_q, out_neg_d;
  logic                 out_last_q, out_last_d;
  logic [NODE_BITS-1:0] out_idx_q, out_idx_d;

  logic                 accept;
  logic [XW-1:0]        ncfg;
  logic [CNT_W-1:0]     n_sat;
  logic                 check_pass;
  logic                 pass_end;
  logic                 idx_last;
  logic [XW-1:0]        idx_x;
  logic [XW-1:0]        from_x;
  logic [XW-1:0]        to_x;

  logic                 e_we;
  logic                 e_re;
  logic [EDGE_W-1:0]    e_rdata;
  logic [NODE_BITS-1:0] e_from;
  logic [NODE_BITS-1:0] e_to;
  logic signed [WEIGHT_BITS-1:0] e_weight;

  logic                 d_we;
  logic [IW-1:0]        d_waddr;
  logic [DREC_W-1:0]    d_wdata;
  logic [IW-1:0]        d_raddr_a;
  logic [IW-1:0]        d_raddr_b;
  logic [DREC_W-1:0]    d_rdata_a;
  logic [DREC_W-1:0]    d_rdata_b;

  bfsp_relax_t          rlx;

  assign busy   = (state_q != ST_IDLE);
  assign accept = start && !busy;

  always_comb begin
    ncfg = XW'(node_count_q);
    if (ncfg == '0) begin
      ncfg = XW'(1);
    end
    if (ncfg > XW'(MAX_NODES)) begin
      ncfg = XW'(MAX_NODES);
    end
    n_sat = ncfg[CNT_W-1:0];
  end

  assign e_from     = e_rdata[EDGE_W-1 -: NODE_BITS];
  assign e_to       = e_rdata[WEIGHT_BITS +: NODE_BITS];
  assign e_weight   = $signed(e_rdata[WEIGHT_BITS-1:0]);
  assign check_pass = (pass_q == n_q - CNT_W'(1));
  assign pass_end   = (ptr_q == count_q);
  assign idx_last   = (idx_q == n_q - CNT_W'(1));
  assign idx_x      = XW'(idx_q);
  assign from_x     = XW'(e_from);
  assign to_x       = XW'(e_to);

  bfsp_edge_mem #(
    .DEPTH (MAX_EDGES),
    .WIDTH (EDGE_W),
    .AW    (EA_W)
  ) u_edge_mem (
    .clk_i   (clk_i),
    .we_i    (e_we),
    .waddr_i (count_q[EA_W-1:0]),
    .wdata_i ({edge_from_i, edge_to_i, edge_weight_i}),
    .re_i    (e_re),
    .raddr_i (ptr_q[EA_W-1:0]),
    .rdata_o (e_rdata)
  );

  bfsp_dist_mem #(
    .DEPTH (MAX_NODES),
    .WIDTH (DREC_W),
    .AW    (IW)
  ) u_dist_mem (
    .clk_i     (clk_i),
    .we_i      (d_we),
    .waddr_i   (d_waddr),
    .wdata_i   (d_wdata),
    .raddr_a_i (d_raddr_a),
    .raddr_b_i (d_raddr_b),
    .rdata_a_o (d_rdata_a),
    .rdata_b_o (d_rdata_b)
  );

  bfsp_relax_unit #(
    .WEIGHT_BITS (WEIGHT_BITS),
    .CNT_W       (CNT_W)
  ) u_relax (
    .from_i   (e_from),
    .to_i     (e_to),
    .weight_i (e_weight),
    .n_i      (n_q),
    .d_from_i (d_rdata_a),
    .d_to_i   (d_rdata_b),
    .res_o    (rlx)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && operation_i) begin
          state_d = ST_CLEAR;
        end
      end
      ST_CLEAR: begin
        if (idx_last) begin
          state_d = ST_FETCH;
        end
      end
      ST_FETCH: begin
        if (!pass_end) begin
          state_d = ST_DREAD;
        end else if (check_pass) begin
          state_d = under_q ? ST_IDLE : ST_EMIT;
        end
      end
      ST_DREAD: begin
        state_d = ST_RELAX;
      end
      ST_RELAX: begin
        state_d = (rlx.relax && check_pass) ? ST_IDLE : ST_FETCH;
      end
      ST_EMIT: begin
        if (idx_last) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // datapath and outputs
  always_comb begin
    node_count_d = node_count_q;
    source_d     = source_q;
    src_run_d    = src_run_q;
    n_d          = n_q;
    count_d      = count_q;
    ptr_d        = ptr_q;
    pass_d       = pass_q;
    idx_d        = idx_q;
    under_d      = under_q;
    out_vld_d    = 1'b0;
    out_neg_d    = 1'b0;
    out_last_d   = 1'b0;
    out_idx_d    = '0;
    e_we         = 1'b0;
    e_re         = 1'b0;
    d_we         = 1'b0;
    d_waddr      = idx_x[IW-1:0];
    d_wdata      = '0;
    d_raddr_a    = from_x[IW-1:0];
    d_raddr_b    = to_x[IW-1:0];

    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_NODE_COUNT:  node_count_d = cfg_wdata_i[NCFG_BITS-1:0];
        REG_SOURCE_NODE: source_d     = cfg_wdata_i[NODE_BITS-1:0];
        default: ;
      endcase
    end

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (!operation_i) begin
            if (count_q < EC_W'(MAX_EDGES)) begin
              e_we    = 1'b1;
              count_d = count_q + EC_W'(1);
            end
          end else begin
            n_d       = n_sat;
            src_run_d = source_q;
            idx_d     = '0;
          end
        end
      end
      ST_CLEAR: begin
        d_we    = 1'b1;
        d_wdata = {(idx_x == XW'(src_run_q)), {DIST_BITS{1'b0}}};
        idx_d   = idx_q + CNT_W'(1);
        if (idx_last) begin
          ptr_d   = '0;
          pass_d  = '0;
          under_d = 1'b0;
        end
      end
      ST_FETCH: begin
        if (!pass_end) begin
          e_re = 1'b1;
        end else if (!check_pass) begin
          pass_d = pass_q + CNT_W'(1);
          ptr_d  = '0;
        end else begin
          count_d = '0;
          ptr_d   = '0;
          idx_d   = '0;
          if (under_q) begin
            out_vld_d  = 1'b1;
            out_neg_d  = 1'b1;
            out_last_d = 1'b1;
          end
        end
      end
      ST_DREAD: begin
      end
      ST_RELAX: begin
        ptr_d = ptr_q + EC_W'(1);
        if (rlx.relax) begin
          if (check_pass) begin
            count_d    = '0;
            ptr_d      = '0;
            out_vld_d  = 1'b1;
            out_neg_d  = 1'b1;
            out_last_d = 1'b1;
          end else if (rlx.under) begin
            under_d = 1'b1;
          end else begin
            d_we    = 1'b1;
            d_waddr = to_x[IW-1:0];
            d_wdata = {1'b1, rlx.sum};
          end
        end
      end
      ST_EMIT: begin
        d_raddr_a  = idx_x[IW-1:0];
        out_vld_d  = 1'b1;
        out_idx_d  = idx_x[NODE_BITS-1:0];
        out_last_d = idx_last;
        idx_d      = idx_q + CNT_W'(1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      node_count_q <= NCFG_BITS'(64);
      source_q     <= '0;
      count_q      <= '0;
      ptr_q        <= '0;
      pass_q       <= '0;
      idx_q        <= '0;
      under_q      <= 1'b0;
      out_vld_q    <= 1'b0;
    end else begin
      state_q      <= state_d;
      node_count_q <= node_count_d;
      source_q     <= source_d;
      count_q      <= count_d;
      ptr_q        <= ptr_d;
      pass_q       <= pass_d;
      idx_q        <= idx_d;
      under_q      <= under_d;
      out_vld_q    <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    src_run_q  <= src_run_d;
    n_q        <= n_d;
    out_neg_q  <= out_neg_d;
    out_last_q <= out_last_d;
    out_idx_q  <= out_idx_d;
  end

  assign result_valid_o   = out_vld_q;
  assign node_index_o     = out_idx_q;
  assign reachable_o      = !out_neg_q && d_rdata_a[DIST_BITS];
  assign distance_o       = reachable_o ? $signed(d_rdata_a[DIST_BITS-1:0]) : '0;
  assign negative_cycle_o = out_neg_q;
  assign last_o           = out_last_q;

endmodule

`default_nettype wire

/* hw/rtl/bfsp_edge_mem.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bfsp_edge_mem
// Edge list storage, one write port and one registered read port.
// ----------------------------------------------------------------------------
module bfsp_edge_mem #(
  parameter int unsigned DEPTH = 4096,
  parameter int unsigned WIDTH = 28,
  parameter int unsigned AW    = 12
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/bfsp_dist_mem.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bfsp_dist_mem
// Per-node distance storage, one write port and two registered read ports.
// ----------------------------------------------------------------------------
module bfsp_dist_mem #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned WIDTH = 23,
  parameter int unsigned AW    = 6
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_a_i,
  input  wire logic [AW-1:0]    raddr_b_i,
  output logic      [WIDTH-1:0] rdata_a_o,
  output logic      [WIDTH-1:0] rdata_b_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_a_o <= mem[raddr_a_i];
    rdata_b_o <= mem[raddr_b_i];
  end

endmodule

`default_nettype wire

/* hw/rtl/bfsp_relax_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bfsp_relax_unit
// Shared add and compare unit that decides whether one edge relaxes.
// ----------------------------------------------------------------------------
module bfsp_relax_unit
  import bfsp_pkg::*;
#(
  parameter int unsigned WEIGHT_BITS = 16,
  parameter int unsigned CNT_W       = 7
) (
  input  wire logic        [NODE_BITS-1:0]   from_i,
  input  wire logic        [NODE_BITS-1:0]   to_i,
  input  wire logic signed [WEIGHT_BITS-1:0] weight_i,
  input  wire logic        [CNT_W-1:0]       n_i,
  input  wire logic        [DIST_BITS:0]     d_from_i,
  input  wire logic        [DIST_BITS:0]     d_to_i,
  output bfsp_relax_t                        res_o
);

  localparam int unsigned XW    = (CNT_W > NODE_BITS) ? CNT_W : NODE_BITS;
  localparam int unsigned SUM_W = ((WEIGHT_BITS > DIST_BITS) ? WEIGHT_BITS : DIST_BITS) + 1;
  localparam logic signed [SUM_W-1:0] SMAX = SUM_W'((2 ** (DIST_BITS - 1)) - 1);
  localparam logic signed [SUM_W-1:0] SMIN = -SMAX - SUM_W'(1);

  logic                    in_range;
  logic signed [SUM_W-1:0] sum;
  logic                    above;
  logic                    no_gain;

  always_comb begin
    in_range = (XW'(from_i) < XW'(n_i)) && (XW'(to_i) < XW'(n_i));
    sum      = SUM_W'($signed(d_from_i[DIST_BITS-1:0])) + SUM_W'(weight_i);
    above    = sum > SMAX;
    no_gain  = d_to_i[DIST_BITS] && (sum >= SUM_W'($signed(d_to_i[DIST_BITS-1:0])));
    res_o.relax = in_range && d_from_i[DIST_BITS] && !above && !no_gain;
    res_o.under = sum < SMIN;
    res_o.sum   = sum[DIST_BITS-1:0];
  end

endmodule

`default_nettype wire

/* verif/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the shortest-path engine. Loads edge lists, starts
// runs and checks every distance or negative-cycle result against a
// Bellman-Ford predictor kept alongside the block.
// ----------------------------------------------------------------------------
module tb;
  import bfsp_pkg::*;

  localparam int     NODES    = 64;
  localparam int     EDGE_CAP = 4096;
  localparam longint DIST_HI  = (longint'(1) <<< 21) - 1;
  localparam longint DIST_LO  = -(longint'(1) <<< 21);

  typedef enum logic {
    OP_STORE = 1'b0,
    OP_RUN   = 1'b1
  } bfsp_op_e;

  typedef struct {
    logic [5:0] tail;
    logic [5:0] head;
    int         weight;
  } graph_edge_t;

  typedef struct {
    logic [5:0]  node;
    logic [21:0] dist_val;
    logic        reach;
    logic        ncyc;
    logic        last;
  } path_result_t;

  logic                clk_i;
  logic                rst_ni;
  logic                start;
  logic                busy;
  logic                cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0]    cfg_wdata_i;
  logic                operation_i;
  logic [5:0]          edge_from_i;
  logic [5:0]          edge_to_i;
  logic signed [15:0]  edge_weight_i;
  logic                result_valid_o;
  logic [5:0]          node_index_o;
  logic signed [21:0]  distance_o;
  logic                reachable_o;
  logic                negative_cycle_o;
  logic                last_o;

  graph_edge_t  edge_list[$];
  path_result_t expected_paths[$];
  longint       path_len[NODES];
  bit           path_ok[NODES];
  bit           sum_under;
  logic [6:0]   node_cnt_q;
  logic [5:0]   source_q;
  int           mismatch_count;
  int           items_sent;
  int           burst_left;
  bit           pace_gaps;

  bellman_ford_shortest_paths u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .busy             (busy),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .operation_i      (operation_i),
    .edge_from_i      (edge_from_i),
    .edge_to_i        (edge_to_i),
    .edge_weight_i    (edge_weight_i),
    .result_valid_o   (result_valid_o),
    .node_index_o     (node_index_o),
    .distance_o       (distance_o),
    .reachable_o      (reachable_o),
    .negative_cycle_o (negative_cycle_o),
    .last_o           (last_o)
  );

  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  initial begin
    #20_000_000;
    $display("Mismatches found");
    $finish;
  end

  // one relaxation sweep in store order
  function automatic bit relax_pass(int n, bit apply);
    longint sum;
    bit     any;
    any = 1'b0;
    foreach (edge_list[k]) begin
      if (edge_list[k].tail >= n || edge_list[k].head >= n || !path_ok[edge_list[k].tail])
        continue;
      sum = path_len[edge_list[k].tail] + longint'(edge_list[k].weight);
      if (sum > DIST_HI)
        continue;
      if (path_ok[edge_list[k].head] && sum >= path_len[edge_list[k].head])
        continue;
      any = 1'b1;
      if (!apply)
        return 1'b1;
      if (sum < DIST_LO) begin
        sum_under = 1'b1;
        continue;
      end
      path_len[edge_list[k].head] = sum;
      path_ok[edge_list[k].head]  = 1'b1;
    end
    return any;
  endfunction

  function automatic void predict_shortest_paths();
    int           n;
    bit           cycle;
    path_result_t r;
    n = node_cnt_q;
    if (n == 0)
      n = 1;
    if (n > NODES)
      n = NODES;
    for (int i = 0; i < NODES; i++) begin
      path_len[i] = 0;
      path_ok[i]  = 1'b0;
    end
    if (source_q < n)
      path_ok[source_q] = 1'b1;
    sum_under = 1'b0;
    for (int rnd = 0; rnd + 1 < n; rnd++)
      void'(relax_pass(n, 1'b1));
    cycle = sum_under || relax_pass(n, 1'b0);
    edge_list.delete();
    if (cycle) begin
      r = '{node: '0, dist_val: '0, reach: 1'b0, ncyc: 1'b1, last: 1'b1};
      expected_paths.push_back(r);
    end else begin
      for (int i = 0; i < n; i++) begin
        r.node     = 6'(i);
        r.dist_val = path_ok[i] ? path_len[i][21:0] : '0;
        r.reach    = path_ok[i];
        r.ncyc     = 1'b0;
        r.last     = (i == n - 1);
        expected_paths.push_back(r);
      end
    end
  endfunction

  function automatic void note_mismatch(string msg);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("mismatch: %s", msg);
  endfunction

  always @(posedge clk_i) begin : check_result
    path_result_t exp_r;
    if (rst_ni && result_valid_o) begin
      if (expected_paths.size() == 0) begin
        note_mismatch($sformatf("unexpected result node %0d dist %0d reach %0b ncyc %0b last %0b",
                                node_index_o, distance_o, reachable_o, negative_cycle_o,
                                last_o));
      end else begin
        exp_r = expected_paths.pop_front();
        if (node_index_o !== exp_r.node || distance_o !== exp_r.dist_val ||
            reachable_o !== exp_r.reach || negative_cycle_o !== exp_r.ncyc ||
            last_o !== exp_r.last)
          note_mismatch($sformatf(
            "exp node %0d dist %0d reach %0b ncyc %0b last %0b, got %0d %0d %0b %0b %0b",
            exp_r.node, $signed(exp_r.dist_val), exp_r.reach, exp_r.ncyc, exp_r.last,
            node_index_o, distance_o, reachable_o, negative_cycle_o, last_o));
      end
    end
  end

  task automatic idle_cycles(int k);
    repeat (k) begin
      @(negedge clk_i);
      start <= 1'b0;
    end
  endtask

  // one command transfer, then model update
  task automatic send_cmd(bfsp_op_e op, logic [5:0] tail, logic [5:0] head,
                          logic [15:0] weight);
    graph_edge_t e;
    if (pace_gaps) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 10);
        idle_cycles($urandom_range(0, 6));
      end
      burst_left--;
    end
    @(negedge clk_i);
    start         <= 1'b1;
    operation_i   <= op;
    edge_from_i   <= tail;
    edge_to_i     <= head;
    edge_weight_i <= weight;
    do @(posedge clk_i); while (busy);
    items_sent++;
    if (op == OP_STORE) begin
      if (edge_list.size() < EDGE_CAP) begin
        e.tail   = tail;
        e.head   = head;
        e.weight = $signed(weight);
        edge_list.push_back(e);
      end
    end else begin
      predict_shortest_paths();
    end
  endtask

  task automatic store_edge(logic [5:0] tail, logic [5:0] head, logic [15:0] weight);
    send_cmd(OP_STORE, tail, head, weight);
  endtask

  task automatic start_run();
    send_cmd(OP_RUN, 6'($urandom), 6'($urandom), 16'($urandom));
  endtask

  task automatic write_reg(bfsp_reg_e idx, logic [CFG_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    if (idx == REG_NODE_COUNT)
      node_cnt_q = data[6:0];
    else
      source_q = data[5:0];
  endtask

  // wait until every expected result has come and the block is idle
  task automatic drain();
    @(negedge clk_i);
    start <= 1'b0;
    while (expected_paths.size() != 0)
      @(posedge clk_i);
    while (busy)
      @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic test_default_graph();
    store_edge(6'd0, 6'd1, 16'sd32767);
    store_edge(6'd1, 6'd63, -16'sd32768);
    store_edge(6'd0, 6'd63, 16'sd5);
    store_edge(6'd62, 6'd0, 16'sd1);
    store_edge(6'd63, 6'd2, 16'sd0);
    start_run();
    drain();
  endtask

  task automatic test_node_count_limits();
    write_reg(REG_NODE_COUNT, 7'd0);
    write_reg(REG_SOURCE_NODE, 7'd0);
    store_edge(6'd0, 6'd0, 16'sd0);
    store_edge(6'd0, 6'd1, -16'sd5);
    start_run();
    drain();
    write_reg(REG_NODE_COUNT, 7'd127);
    store_edge(6'd0, 6'd63, -16'sd32768);
    store_edge(6'd63, 6'd62, 16'sd32767);
    start_run();
    drain();
    write_reg(REG_NODE_COUNT, 7'd1);
    start_run();
    drain();
  endtask

  task automatic test_source_out_of_range();
    write_reg(REG_NODE_COUNT, 7'd10);
    write_reg(REG_SOURCE_NODE, 7'd63);
    store_edge(6'd0, 6'd1, 16'sd3);
    store_edge(6'd1, 6'd2, 16'sd4);
    start_run();
    drain();
    write_reg(REG_SOURCE_NODE, 7'd9);
    store_edge(6'd9, 6'd0, -16'sd32768);
    store_edge(6'd0, 6'd5, 16'sd100);
    store_edge(6'd5, 6'd12, 16'sd1);
    store_edge(6'd12, 6'd3, 16'sd1);
    start_run();
    start_run();
    drain();
  endtask

  task automatic test_negative_cycles();
    write_reg(REG_NODE_COUNT, 7'd4);
    write_reg(REG_SOURCE_NODE, 7'd0);
    store_edge(6'd0, 6'd1, 16'sd1);
    store_edge(6'd1, 6'd2, -16'sd3);
    store_edge(6'd2, 6'd1, 16'sd1);
    start_run();
    start_run();
    drain();
    // self loops push the sum below range
    write_reg(REG_NODE_COUNT, 7'd64);
    repeat (3) store_edge(6'd0, 6'd0, -16'sd32768);
    start_run();
    drain();
  endtask

  task automatic test_random_graphs();
    int          n;
    int          num_edges;
    logic [5:0]  a;
    logic [5:0]  b;
    logic [15:0] w;
    int          start_count;
    start_count = items_sent;
    while (items_sent - start_count < 70) begin
      case ($urandom_range(0, 9)) inside
        0:       write_reg(REG_NODE_COUNT, 7'd0);
        1:       write_reg(REG_NODE_COUNT, 7'($urandom_range(65, 127)));
        [2:3]:   write_reg(REG_NODE_COUNT, 7'd64);
        default: write_reg(REG_NODE_COUNT, 7'($urandom_range(1, 12)));
      endcase
      n = (node_cnt_q == 0) ? 1 : (node_cnt_q > NODES) ? NODES : node_cnt_q;
      case ($urandom_range(0, 9)) inside
        0:       write_reg(REG_SOURCE_NODE, 7'($urandom_range(0, 63)));
        [1:3]:   write_reg(REG_SOURCE_NODE, 7'd0);
        default: write_reg(REG_SOURCE_NODE, 7'($urandom_range(0, n - 1)));
      endcase
      pace_gaps  = ($urandom_range(0, 3) != 0);
      burst_left = 0;
      num_edges  = $urandom_range(0, 12);
      repeat (num_edges) begin
        if ($urandom_range(0, 9) < 7 && n > 1) begin
          // forward edge, cannot form a loop
          a = 6'($urandom_range(0, n - 2));
          b = 6'($urandom_range(a + 1, n - 1));
          case ($urandom_range(0, 3))
            0:       w = 16'($urandom);
            1:       w = 16'(-$urandom_range(1, 100));
            default: w = 16'($urandom_range(0, 2000));
          endcase
        end else begin
          a = 6'($urandom);
          b = 6'($urandom);
          w = ($urandom_range(0, 1) != 0) ? 16'($urandom) : 16'($urandom_range(0, 500));
        end
        store_edge(a, b, w);
      end
      start_run();
      if ($urandom_range(0, 7) == 0)
        start_run();
      drain();
    end
    pace_gaps = 1'b1;
  endtask

  initial begin
    rst_ni         = 1'b0;
    start          = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_idx_i      = REG_NODE_COUNT;
    cfg_wdata_i    = '0;
    operation_i    = OP_STORE;
    edge_from_i    = '0;
    edge_to_i      = '0;
    edge_weight_i  = '0;
    node_cnt_q     = 7'd64;
    source_q       = 6'd0;
    mismatch_count = 0;
    items_sent     = 0;
    burst_left     = 0;
    pace_gaps      = 1'b1;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;

    test_default_graph();
    test_node_count_limits();
    test_source_out_of_range();
    test_negative_cycles();
    test_random_graphs();
    drain();

    if (mismatch_count == 0 && expected_paths.size() == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule

/* filelist.f */
hw/rtl/bfsp_pkg.sv
hw/rtl/bfsp_edge_mem.sv
hw/rtl/bfsp_dist_mem.sv
hw/rtl/bfsp_relax_unit.sv
hw/rtl/bellman_ford_shortest_paths.sv
verif/tb.sv
